@@ sv/kpt_pkg.sv @@
// Package: command and status codes, widths and table entry type for the task table.
`default_nettype none

package kpt_pkg;

  localparam int DEPTH_DEF = 64;

  localparam int FUNC_W = 2;
  localparam int ID_W   = 16;
  localparam int PRIO_W = 31;
  localparam int STAT_W = 2;

  localparam logic [FUNC_W-1:0] F_ADD    = 2'd0;
  localparam logic [FUNC_W-1:0] F_CHANGE = 2'd1;
  localparam logic [FUNC_W-1:0] F_REMOVE = 2'd2;
  localparam logic [FUNC_W-1:0] F_POP    = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic [ID_W-1:0]   uid;
    logic [ID_W-1:0]   tid;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

@@ sv/kpt_cmd_if.sv @@
// Interface: command channel (valid/ready with one command item).
`default_nettype none

interface kpt_cmd_if;
  logic                      valid;
  logic                      ready;
  logic [kpt_pkg::FUNC_W-1:0] func;
  logic [kpt_pkg::ID_W-1:0]   user_id;
  logic [kpt_pkg::ID_W-1:0]   task_id;
  logic [kpt_pkg::PRIO_W-1:0] priority_req;

  modport source (output valid, func, user_id, task_id, priority_req, input ready);
  modport sink   (input valid, func, user_id, task_id, priority_req, output ready);
endinterface

`default_nettype wire

@@ sv/kpt_rsp_if.sv @@
// Interface: response channel (valid/ready with one status item).
`default_nettype none

interface kpt_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [kpt_pkg::STAT_W-1:0] status;
  logic [kpt_pkg::ID_W-1:0]   owner;

  modport source (output valid, status, owner, input ready);
  modport sink   (input valid, status, owner, output ready);
endinterface

`default_nettype wire

@@ sv/kpt_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
`default_nettype none

module kpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ sv/keyed_priority_task_table_top.sv @@
// Top level: keyed priority task table held in one RAM with a fill count.
//
//   channel | dir | payload                                    | handshake
//   --------+-----+--------------------------------------------+-----------
//   cmd     | in  | func, user_id, task_id, priority_req       | valid/ready
//   rsp     | out | status, owner                              | valid/ready
//
// Flow: one item at a time, one RAM read per cycle in the scan. After accept, the scan
//   stops at a key match or reads all live entries (pop, misses), then S_ACT acts,
//   a removal that moves the last entry adds S_MVRD and S_MVWR, and S_RESP answers.
// Reset: synchronous; clears the fill count and the control state, not the RAM:
//   only slots below the fill count are ever read as live.
// Stalls: a finished response holds in the output register while the next item runs.
`default_nettype none

module keyed_priority_task_table_top #(
  parameter int DEPTH = kpt_pkg::DEPTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  kpt_cmd_if.sink    cmd,
  kpt_rsp_if.source  rsp
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_ACT  = 3'd2;
  localparam logic [2:0] S_MVRD = 3'd3;
  localparam logic [2:0] S_MVWR = 3'd4;
  localparam logic [2:0] S_RESP = 3'd5;

  logic [2:0] state;

  // live entries occupy slots 0 .. cnt-1
  logic [CW-1:0] cnt;
  logic [CW-1:0] iss;       // next slot to read
  logic [AW-1:0] chk;       // slot whose data is on the RAM output
  logic          chk_vld;

  // latched command
  logic [kpt_pkg::FUNC_W-1:0] op_func;
  logic [kpt_pkg::ID_W-1:0]   op_uid;
  logic [kpt_pkg::ID_W-1:0]   op_tid;
  logic [kpt_pkg::PRIO_W-1:0] op_pri;

  // lookup result: matching slot, or best slot so far for pop
  logic                       found;
  logic [AW-1:0]              slot;
  logic [kpt_pkg::ID_W-1:0]   hold_user;
  logic [kpt_pkg::PRIO_W-1:0] best_pri;
  logic [kpt_pkg::ID_W-1:0]   best_tid;

  logic [kpt_pkg::STAT_W-1:0] res_status;
  logic [kpt_pkg::ID_W-1:0]   res_owner;

  // output register
  logic                       rsp_valid;
  logic [kpt_pkg::STAT_W-1:0] rsp_status;
  logic [kpt_pkg::ID_W-1:0]   rsp_owner;

  // RAM port
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  kpt_pkg::entry_t        ram_wdata;
  logic [AW-1:0]          ram_raddr;
  logic [kpt_pkg::ENTRY_W-1:0] ram_rdata;
  kpt_pkg::entry_t        rd;

  logic [CW-1:0] last_c;
  logic [AW-1:0] last;
  logic          is_pop;
  logic          better;
  logic          full;

  assign rd     = kpt_pkg::entry_t'(ram_rdata);
  assign last_c = cnt - CW'(1);
  assign last   = last_c[AW-1:0];
  assign is_pop = (op_func == kpt_pkg::F_POP);
  assign full   = (cnt == CW'(DEPTH));
  assign better = !found || (rd.prio > best_pri)
                  || ((rd.prio == best_pri) && (rd.tid > best_tid));

  assign cmd.ready  = (state == S_IDLE);
  assign rsp.valid  = rsp_valid;
  assign rsp.status = rsp_status;
  assign rsp.owner  = rsp_owner;

  kpt_ram #(
    .WIDTH (kpt_pkg::ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // RAM controls: scan reads, the action writes, a removal copies the last entry
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = slot;
    ram_wdata = '{uid: op_uid, tid: op_tid, prio: op_pri};
    ram_raddr = iss[AW-1:0];
    case (state)
      S_ACT: begin
        case (op_func)
          kpt_pkg::F_ADD: begin
            ram_we    = found || !full;
            ram_waddr = found ? slot : cnt[AW-1:0];
          end
          kpt_pkg::F_CHANGE: begin
            ram_we    = found;
            ram_wdata = '{uid: hold_user, tid: op_tid, prio: op_pri};
          end
          default: ram_we = 1'b0;
        endcase
      end
      S_MVRD: ram_raddr = last;
      S_MVWR: begin
        ram_we    = 1'b1;
        ram_wdata = rd;
      end
      default: ram_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      chk_vld   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      // drop the response once it is taken, unless S_RESP reloads the register
      if (rsp_valid && rsp.ready && (state != S_RESP)) begin
        rsp_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            op_func    <= cmd.func;
            op_uid     <= cmd.user_id;
            op_tid     <= cmd.task_id;
            op_pri     <= cmd.priority_req;
            iss        <= '0;
            chk_vld    <= 1'b0;
            found      <= 1'b0;
            res_status <= kpt_pkg::ST_OK;
            res_owner  <= '0;
            state      <= S_SCAN;
          end
        end

        S_SCAN: begin
          // pop: keep the best entry seen so far
          if (chk_vld && is_pop && better) begin
            found     <= 1'b1;
            slot      <= chk;
            best_pri  <= rd.prio;
            best_tid  <= rd.tid;
            res_owner <= rd.uid;
          end
          if (chk_vld && !is_pop && (rd.tid == op_tid)) begin
            // key match: stop the scan early
            found     <= 1'b1;
            slot      <= chk;
            hold_user <= rd.uid;
            chk_vld   <= 1'b0;
            state     <= S_ACT;
          end else if (!chk_vld && (iss >= cnt)) begin
            state <= S_ACT;
          end else if (iss < cnt) begin
            iss     <= iss + CW'(1);
            chk     <= iss[AW-1:0];
            chk_vld <= 1'b1;
          end else begin
            chk_vld <= 1'b0;
          end
        end

        S_ACT: begin
          state <= S_RESP;
          case (op_func)
            kpt_pkg::F_ADD: begin
              if (!found) begin
                if (full) begin
                  res_status <= kpt_pkg::ST_FULL;
                end else begin
                  cnt <= cnt + CW'(1);
                end
              end
            end
            kpt_pkg::F_CHANGE: begin
              if (!found) begin
                res_status <= kpt_pkg::ST_NOT_FOUND;
              end
            end
            default: begin
              // remove and pop: fill the hole with the last entry
              if (!found) begin
                res_status <= is_pop ? kpt_pkg::ST_EMPTY : kpt_pkg::ST_NOT_FOUND;
              end else if (slot == last) begin
                cnt <= last_c;
              end else begin
                state <= S_MVRD;
              end
            end
          endcase
        end

        S_MVRD: begin
          state <= S_MVWR;
        end

        S_MVWR: begin
          cnt   <= last_c;
          state <= S_RESP;
        end

        S_RESP: begin
          // hold until the output register is free
          if (!rsp_valid || rsp.ready) begin
            rsp_valid  <= 1'b1;
            rsp_status <= res_status;
            rsp_owner  <= res_owner;
            state      <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(DEPTH))
    else $error("fill count beyond table depth");

  a_cnt_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (cnt == $past(cnt)) || (cnt == $past(cnt) + CW'(1))
                    || (cnt == $past(cnt) - CW'(1)))
    else $error("fill count moved by more than one");

  a_scan_live: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) && chk_vld |-> (CW'(chk) < cnt))
    else $error("scan compared a slot beyond the fill count");

  a_empty_owner: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status != kpt_pkg::ST_OK) |-> (rsp_owner == '0))
    else $error("owner set on a failed command");

endmodule

`default_nettype wire
